/* design/wmas_pkg.sv */
`default_nettype none

package wmas_pkg;

   localparam int DEF_HALF_LIMBS = 6;
   localparam int DEF_LIMB_BITS  = 64;

   // Modulus register file seen on the control port.
   localparam int MOD_REGS   = 6;
   localparam int MOD_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   localparam int INDEX_W = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_SUB = 1'b1;

   // Token kinds passed from the front to the back through the queue.
   localparam logic KIND_EMIT  = 1'b0;
   localparam logic KIND_BURST = 1'b1;

   typedef struct packed {
      logic en;
      logic bank;
   } st_wr_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } done_type;

endpackage

`default_nettype wire

/* design/wmas_queue.sv */
`default_nettype none

module wmas_queue
   import wmas_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   logic [WIDTH-1:0]       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

/* design/wmas_front.sv */
`default_nettype none

module wmas_front
   import wmas_pkg::*;
#(
   parameter int HALF_LIMBS = DEF_HALF_LIMBS,
   parameter int LIMB_BITS  = DEF_LIMB_BITS,
   localparam int IDX_W     = (HALF_LIMBS > 1) ? $clog2(HALF_LIMBS) : 1
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_push,
   output logic                                          req_full,
   input  wire logic                                     req_cmd,
   input  wire logic [LIMB_BITS-1:0]                     req_limb_a,
   input  wire logic [LIMB_BITS-1:0]                     req_limb_b,
   input  wire logic [MOD_REGS-1:0][CSR_DATA_W-1:0]      mod_limbs,
   input  wire logic                                     q_full,
   output logic                                          q_push,
   output logic      [LIMB_BITS+INDEX_W+2:0]             q_data,
   output st_wr_type                                     st_wr,
   output logic      [IDX_W-1:0]                         st_idx,
   output logic      [LIMB_BITS-1:0]                     st_hi,
   output logic      [LIMB_BITS-1:0]                     st_cand,
   input  done_type                                      done
);

   localparam int POS_W = $clog2(2 * HALF_LIMBS);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(2 * HALF_LIMBS - 1);
   localparam logic [POS_W-1:0] HALF_POS = POS_W'(HALF_LIMBS);

   // Stage A: position, latched command and the main carry loop.
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               op_ff, op_in;
   logic               mc_ff, mc_in;
   logic               bank_ff, bank_in;
   logic               a_fire;
   logic               a_first;
   logic               a_last;
   logic               a_op;
   logic               a_cin;
   logic [LIMB_BITS:0] a_sum;

   // Stage B: correction chain, store writes and queue tokens.
   logic                 b_valid_ff, b_valid_in;
   logic [LIMB_BITS-1:0] b_v_ff;
   logic [POS_W-1:0]     b_pos_ff;
   logic                 b_op_ff;
   logic                 b_mc_ff;
   logic                 b_bank_ff;
   logic                 cc_ff, cc_in;
   logic [1:0]           busy_ff, busy_in;
   logic                 b_high;
   logic                 b_last;
   logic [IDX_W-1:0]     b_i;
   logic [LIMB_BITS-1:0] b_mod;
   logic                 b_cin;
   logic [LIMB_BITS:0]   b_corr;
   logic                 b_use_cand;
   logic                 b_adv;

   assign a_first = pos_ff == '0;
   assign a_last  = pos_ff == LAST_POS;
   assign a_op    = a_first ? req_cmd : op_ff;
   assign a_cin   = a_first ? 1'b0 : mc_ff;
   assign a_fire  = req_push && !req_full;

   always_comb begin
      if (a_op == CMD_ADD) begin
         a_sum = {1'b0, req_limb_a} + {1'b0, req_limb_b} + (LIMB_BITS+1)'(a_cin);
      end else begin
         a_sum = {1'b0, req_limb_a} - {1'b0, req_limb_b} - (LIMB_BITS+1)'(a_cin);
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      op_in   = op_ff;
      mc_in   = mc_ff;
      bank_in = bank_ff;
      if (a_fire) begin
         op_in   = a_op;
         mc_in   = a_sum[LIMB_BITS];
         pos_in  = a_last ? '0 : pos_ff + 1'b1;
         bank_in = a_last ? ~bank_ff : bank_ff;
      end
   end

   assign b_high = b_pos_ff >= HALF_POS;
   assign b_last = b_pos_ff == LAST_POS;
   assign b_i    = IDX_W'(b_pos_ff - HALF_POS);
   assign b_cin  = (b_i == '0) ? 1'b0 : cc_ff;

   // Modulus limbs above the register file are zero.
   always_comb begin
      if (32'(b_i) < MOD_REGS) begin
         b_mod = mod_limbs[MOD_IDX_W'(b_i)][LIMB_BITS-1:0];
      end else begin
         b_mod = '0;
      end
   end

   always_comb begin
      if (b_op_ff == CMD_ADD) begin
         b_corr = {1'b0, b_v_ff} - {1'b0, b_mod} - (LIMB_BITS+1)'(b_cin);
      end else begin
         b_corr = {1'b0, b_v_ff} + {1'b0, b_mod} + (LIMB_BITS+1)'(b_cin);
      end
   end

   // Add keeps the plain high half only with no carry out and hi below p.
   assign b_use_cand = (b_op_ff == CMD_ADD) ? !(b_corr[LIMB_BITS] && !b_mc_ff) : b_mc_ff;

   // A high limb waits while its store bank is still being read out.
   always_comb begin
      b_adv = 1'b0;
      if (b_valid_ff) begin
         if (b_high) begin
            b_adv = !busy_ff[b_bank_ff] && (!b_last || !q_full);
         end else begin
            b_adv = !q_full;
         end
      end
   end

   assign req_full   = b_valid_ff && !b_adv;
   assign b_valid_in = a_fire || (b_valid_ff && !b_adv);

   assign q_push = b_adv && (!b_high || b_last);
   assign q_data = {(b_high ? KIND_BURST : KIND_EMIT), b_use_cand, b_bank_ff,
                    INDEX_W'(b_pos_ff), b_v_ff};

   assign st_wr.en   = b_adv && b_high;
   assign st_wr.bank = b_bank_ff;
   assign st_idx     = b_i;
   assign st_hi      = b_v_ff;
   assign st_cand    = b_corr[LIMB_BITS-1:0];

   always_comb begin
      cc_in = cc_ff;
      if (b_adv && b_high) begin
         cc_in = b_corr[LIMB_BITS];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (done.valid) begin
         busy_in[done.bank] = 1'b0;
      end
      if (q_push && b_high) begin
         busy_in[b_bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         op_ff      <= CMD_ADD;
         mc_ff      <= 1'b0;
         bank_ff    <= 1'b0;
         b_valid_ff <= 1'b0;
         cc_ff      <= 1'b0;
         busy_ff    <= '0;
      end else begin
         pos_ff     <= pos_in;
         op_ff      <= op_in;
         mc_ff      <= mc_in;
         bank_ff    <= bank_in;
         b_valid_ff <= b_valid_in;
         cc_ff      <= cc_in;
         busy_ff    <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         b_v_ff    <= a_sum[LIMB_BITS-1:0];
         b_pos_ff  <= pos_ff;
         b_op_ff   <= a_op;
         b_mc_ff   <= a_sum[LIMB_BITS];
         b_bank_ff <= bank_ff;
      end
   end

endmodule

`default_nettype wire

/* design/wmas_back.sv */
`default_nettype none

module wmas_back
   import wmas_pkg::*;
#(
   parameter int HALF_LIMBS = DEF_HALF_LIMBS,
   parameter int LIMB_BITS  = DEF_LIMB_BITS,
   localparam int IDX_W     = (HALF_LIMBS > 1) ? $clog2(HALF_LIMBS) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_empty,
   input  wire logic [LIMB_BITS+INDEX_W+2:0] q_data,
   output logic                              q_pop,
   input  st_wr_type                         st_wr,
   input  wire logic [IDX_W-1:0]             st_idx,
   input  wire logic [LIMB_BITS-1:0]         st_hi,
   input  wire logic [LIMB_BITS-1:0]         st_cand,
   output done_type                          done,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output logic      [LIMB_BITS-1:0]         rsp_result_limb,
   output logic      [INDEX_W-1:0]           rsp_limb_index,
   output logic                              rsp_last
);

   localparam int POS_W = $clog2(2 * HALF_LIMBS);
   localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(HALF_LIMBS - 1);

   logic [LIMB_BITS-1:0] hi_mem_ff   [2][HALF_LIMBS];
   logic [LIMB_BITS-1:0] cand_mem_ff [2][HALF_LIMBS];

   logic [LIMB_BITS-1:0] t_limb;
   logic [INDEX_W-1:0]   t_index;
   logic                 t_bank;
   logic                 t_use;
   logic                 t_kind;

   logic                 burst_ff, burst_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic                 bbank_ff, bbank_in;
   logic                 buse_ff, buse_in;

   logic                 rd_bank;
   logic [IDX_W-1:0]     rd_cnt;
   logic                 rd_use;
   logic [LIMB_BITS-1:0] rd_limb;
   logic [INDEX_W-1:0]   rd_index;
   logic                 rd_last;

   logic                 out_valid_ff, out_valid_in;
   logic [LIMB_BITS-1:0] out_limb_ff;
   logic [INDEX_W-1:0]   out_index_ff;
   logic                 out_last_ff;
   logic                 slot_free;
   logic                 load;
   logic [LIMB_BITS-1:0] ld_limb;
   logic [INDEX_W-1:0]   ld_index;
   logic                 ld_last;

   assign t_limb  = q_data[LIMB_BITS-1:0];
   assign t_index = q_data[LIMB_BITS+INDEX_W-1:LIMB_BITS];
   assign t_bank  = q_data[LIMB_BITS+INDEX_W];
   assign t_use   = q_data[LIMB_BITS+INDEX_W+1];
   assign t_kind  = q_data[LIMB_BITS+INDEX_W+2];

   // The readout address comes from the running burst, or from a burst
   // token at the head of the queue so that its first limb goes out at once.
   assign rd_bank  = burst_ff ? bbank_ff : t_bank;
   assign rd_cnt   = burst_ff ? cnt_ff : '0;
   assign rd_use   = burst_ff ? buse_ff : t_use;
   assign rd_limb  = rd_use ? cand_mem_ff[rd_bank][rd_cnt] : hi_mem_ff[rd_bank][rd_cnt];
   assign rd_index = INDEX_W'(POS_W'(HALF_LIMBS) + POS_W'(rd_cnt));
   assign rd_last  = rd_cnt == LAST_CNT;

   assign slot_free = !out_valid_ff || rsp_pop;

   always_comb begin
      load     = 1'b0;
      ld_limb  = rd_limb;
      ld_index = rd_index;
      ld_last  = rd_last;
      q_pop    = 1'b0;
      burst_in = burst_ff;
      cnt_in   = cnt_ff;
      bbank_in = bbank_ff;
      buse_in  = buse_ff;
      done     = '0;
      if (burst_ff) begin
         if (slot_free) begin
            load = 1'b1;
            if (rd_last) begin
               burst_in   = 1'b0;
               done.valid = 1'b1;
               done.bank  = bbank_ff;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
      end else if (!q_empty) begin
         if (t_kind == KIND_BURST) begin
            q_pop    = 1'b1;
            bbank_in = t_bank;
            buse_in  = t_use;
            if (slot_free) begin
               load = 1'b1;
               if (rd_last) begin
                  done.valid = 1'b1;
                  done.bank  = t_bank;
               end else begin
                  burst_in = 1'b1;
                  cnt_in   = IDX_W'(1);
               end
            end else begin
               burst_in = 1'b1;
               cnt_in   = '0;
            end
         end else if (slot_free) begin
            q_pop    = 1'b1;
            load     = 1'b1;
            ld_limb  = t_limb;
            ld_index = t_index;
            ld_last  = 1'b0;
         end
      end
   end

   assign out_valid_in = load || (out_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff     <= 1'b0;
         cnt_ff       <= '0;
         bbank_ff     <= 1'b0;
         buse_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         burst_ff     <= burst_in;
         cnt_ff       <= cnt_in;
         bbank_ff     <= bbank_in;
         buse_ff      <= buse_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_limb_ff  <= ld_limb;
         out_index_ff <= ld_index;
         out_last_ff  <= ld_last;
      end
   end

   always_ff @(posedge clock) begin
      if (st_wr.en) begin
         hi_mem_ff[st_wr.bank][st_idx]   <= st_hi;
         cand_mem_ff[st_wr.bank][st_idx] <= st_cand;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_result_limb = out_limb_ff;
   assign rsp_limb_index  = out_index_ff;
   assign rsp_last        = out_last_ff;

endmodule

`default_nettype wire

/* design/wide_modular_add_sub_mod_pr.sv */
// Channel   Direction  Handshake                 Payload
// req       in         req_push / req_full       req_cmd, req_limb_a, req_limb_b
// rsp       out        rsp_empty / rsp_pop       rsp_result_limb, rsp_limb_index, rsp_last
// csr       in/out     APB, pready always high   modulus limbs 0..5 at byte address 8*i
//
// One limb pair is taken per cycle while req_full is low; an operation of 2*HALF_LIMBS
// transactions gives 2*HALF_LIMBS result limbs, one per cycle while rsp_pop stays high,
// so the sustained rate is one per cycle. A low limb passes the stage B registers, the
// queue and the output register on its way out; the high limbs follow the last limb pair.
// The input stalls when the four-entry queue between front and back is full, or when a
// high limb would overwrite the store bank that is still being read out.
// Reset is synchronous and clears control state; the stores need no clearing pass.
`default_nettype none

module wide_modular_add_sub_mod_pr
   import wmas_pkg::*;
#(
   parameter int HALF_LIMBS = DEF_HALF_LIMBS,
   parameter int LIMB_BITS  = DEF_LIMB_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic                  req_cmd,
   input  wire logic [LIMB_BITS-1:0]  req_limb_a,
   input  wire logic [LIMB_BITS-1:0]  req_limb_b,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic      [LIMB_BITS-1:0]  rsp_result_limb,
   output logic      [INDEX_W-1:0]    rsp_limb_index,
   output logic                       rsp_last,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int IDX_W = (HALF_LIMBS > 1) ? $clog2(HALF_LIMBS) : 1;
   localparam int TOK_W = LIMB_BITS + INDEX_W + 3;

   logic [MOD_REGS-1:0][CSR_DATA_W-1:0] mod_ff;
   logic [MOD_IDX_W-1:0]                csr_idx;
   logic                                csr_wr;

   logic             q_push;
   logic [TOK_W-1:0] q_wdata;
   logic             q_full;
   logic             q_pop;
   logic [TOK_W-1:0] q_rdata;
   logic             q_empty;

   st_wr_type            st_wr;
   logic [IDX_W-1:0]     st_idx;
   logic [LIMB_BITS-1:0] st_hi;
   logic [LIMB_BITS-1:0] st_cand;
   done_type             done;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      if (32'(csr_idx) < MOD_REGS) begin
         csr_prdata = mod_ff[csr_idx];
      end else begin
         csr_prdata = '0;
      end
   end

   // Writes past the last modulus register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= '0;
      end else if (csr_wr && (32'(csr_idx) < MOD_REGS)) begin
         mod_ff[csr_idx] <= csr_pwdata;
      end
   end

   wmas_front #(
      .HALF_LIMBS (HALF_LIMBS),
      .LIMB_BITS  (LIMB_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_cmd    (req_cmd),
      .req_limb_a (req_limb_a),
      .req_limb_b (req_limb_b),
      .mod_limbs  (mod_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_wdata),
      .st_wr      (st_wr),
      .st_idx     (st_idx),
      .st_hi      (st_hi),
      .st_cand    (st_cand),
      .done       (done)
   );

   wmas_queue #(
      .WIDTH (TOK_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   wmas_back #(
      .HALF_LIMBS (HALF_LIMBS),
      .LIMB_BITS  (LIMB_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_rdata),
      .q_pop           (q_pop),
      .st_wr           (st_wr),
      .st_idx          (st_idx),
      .st_hi           (st_hi),
      .st_cand         (st_cand),
      .done            (done),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_limb (rsp_result_limb),
      .rsp_limb_index  (rsp_limb_index),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

/* design/wmas_checker.sv */
`default_nettype none

module wmas_checker
   import wmas_pkg::*;
#(
   parameter int HALF_LIMBS = DEF_HALF_LIMBS,
   parameter int LIMB_BITS  = DEF_LIMB_BITS
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_full,
   input wire logic                 rsp_empty,
   input wire logic                 rsp_pop,
   input wire logic [LIMB_BITS-1:0] rsp_result_limb,
   input wire logic [INDEX_W-1:0]   rsp_limb_index,
   input wire logic                 rsp_last
);

   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(2 * HALF_LIMBS - 1);

   // After reset nothing is waiting and the input side is open.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("reset did not clear the result side or left the input stalled");

   // The final limb of a result always carries the top limb position.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last |-> rsp_limb_index == LAST_INDEX)
      else $error("final limb shown with the wrong limb position");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("waiting result withdrawn before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_result_limb) && $stable(rsp_limb_index)
                                 && $stable(rsp_last))
      else $error("waiting result changed before it was taken");

endmodule

bind wide_modular_add_sub_mod_pr wmas_checker #(
   .HALF_LIMBS (HALF_LIMBS),
   .LIMB_BITS  (LIMB_BITS)
) u_wmas_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_result_limb (rsp_result_limb),
   .rsp_limb_index  (rsp_limb_index),
   .rsp_last        (rsp_last)
);

`default_nettype wire

/* sim/tb_top.sv */
module tb_top;
   import wmas_pkg::*;

   localparam int HALF          = DEF_HALF_LIMBS;
   localparam int LIMB_W        = DEF_LIMB_BITS;
   localparam int OP_ITEMS      = 2 * HALF;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PERCENT  = 31;
   localparam int PRINT_CAP     = 40;

   typedef struct packed {
      logic              cmd;
      logic [LIMB_W-1:0] a;
      logic [LIMB_W-1:0] b;
   } limb_pair_type;

   typedef struct packed {
      logic [LIMB_W-1:0]  limb;
      logic [INDEX_W-1:0] index;
      logic               last;
   } result_limb_type;

   typedef enum int {MOD_RANDOM, MOD_ONES, MOD_ZERO, MOD_ONE, MOD_SMALL_TOP} modulus_kind_type;

   typedef enum int {
      OPND_RANDOM, OPND_MODULUS, OPND_NEAR_MODULUS, OPND_ONES, OPND_ZERO, OPND_SMALL_HIGH
   } operand_kind_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic                  req_cmd = CMD_ADD;
   logic [LIMB_W-1:0]     req_limb_a = '0;
   logic [LIMB_W-1:0]     req_limb_b = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [LIMB_W-1:0]     rsp_result_limb;
   logic [INDEX_W-1:0]    rsp_limb_index;
   logic                  rsp_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   wide_modular_add_sub_mod_pr DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_limb_a      (req_limb_a),
      .req_limb_b      (req_limb_b),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_limb (rsp_result_limb),
      .rsp_limb_index  (rsp_limb_index),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // Predictor state, a private copy of what the block holds.
   logic [LIMB_W-1:0] modulus_p [MOD_REGS];
   int                limb_pos = 0;
   logic              op_cmd = CMD_ADD;
   logic              main_cy = 1'b0;
   logic              corr_cy = 1'b0;
   logic [LIMB_W-1:0] hi_store [HALF];
   logic [LIMB_W-1:0] cand_store [HALF];

   limb_pair_type   staged [$];
   limb_pair_type   pair_queue [$];
   result_limb_type result_limbs_due [$];
   limb_pair_type   sent_pair;
   limb_pair_type   next_pair;
   result_limb_type want;
   int              errors = 0;
   int              cycle_count = 0;
   logic            no_gaps = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic advance_mod_add_sub(input limb_pair_type pair);
      logic [LIMB_W:0] sum;
      result_limb_type limb_out;
      int              slot;
      logic            take_cand;
      if (limb_pos == 0) begin
         op_cmd  = pair.cmd;
         main_cy = 1'b0;
         corr_cy = 1'b0;
      end
      if (op_cmd == CMD_ADD)
         sum = {1'b0, pair.a} + {1'b0, pair.b} + (LIMB_W+1)'(main_cy);
      else
         sum = {1'b0, pair.a} - {1'b0, pair.b} - (LIMB_W+1)'(main_cy);
      main_cy = sum[LIMB_W];
      if (limb_pos < HALF) begin
         // The low half is never touched by the reduction.
         limb_out.limb  = sum[LIMB_W-1:0];
         limb_out.index = INDEX_W'(limb_pos);
         limb_out.last  = 1'b0;
         result_limbs_due.push_back(limb_out);
         limb_pos++;
      end else begin
         slot = limb_pos - HALF;
         hi_store[slot] = sum[LIMB_W-1:0];
         if (op_cmd == CMD_ADD)
            sum = {1'b0, hi_store[slot]} - {1'b0, modulus_p[slot]} - (LIMB_W+1)'(corr_cy);
         else
            sum = {1'b0, hi_store[slot]} + {1'b0, modulus_p[slot]} + (LIMB_W+1)'(corr_cy);
         cand_store[slot] = sum[LIMB_W-1:0];
         corr_cy = sum[LIMB_W];
         if (slot < HALF - 1) begin
            limb_pos++;
         end else begin
            if (op_cmd == CMD_ADD)
               take_cand = !(corr_cy && !main_cy);
            else
               take_cand = main_cy;
            for (int k = 0; k < HALF; k++) begin
               limb_out.limb  = take_cand ? cand_store[k] : hi_store[k];
               limb_out.index = INDEX_W'(HALF + k);
               limb_out.last  = (k == HALF - 1);
               result_limbs_due.push_back(limb_out);
            end
            limb_pos = 0;
            main_cy  = 1'b0;
            corr_cy  = 1'b0;
         end
      end
   endtask

   function automatic logic [LIMB_W-1:0] operand_limb(input operand_kind_type kind, input int k);
      logic [LIMB_W-1:0] r;
      r = {$urandom, $urandom};
      case (kind)
         OPND_MODULUS: if (k >= HALF) r = modulus_p[k-HALF];
         OPND_NEAR_MODULUS: begin
            // A high half one below, at or one above p lands on the reduction edge.
            if (k >= HALF) r = modulus_p[k-HALF];
            if (k == HALF) r = r + LIMB_W'($urandom_range(0, 2)) - LIMB_W'(1);
         end
         OPND_ONES: r = '1;
         OPND_ZERO: r = '0;
         OPND_SMALL_HIGH: if (k >= HALF) r = LIMB_W'($urandom_range(0, 65535));
         default: ;
      endcase
      return r;
   endfunction

   task automatic stage_operation(input logic cmd);
      limb_pair_type    item;
      operand_kind_type kind_a;
      operand_kind_type kind_b;
      kind_a = operand_kind_type'($urandom_range(OPND_RANDOM, OPND_SMALL_HIGH));
      kind_b = operand_kind_type'($urandom_range(OPND_RANDOM, OPND_SMALL_HIGH));
      for (int k = 0; k < OP_ITEMS; k++) begin
         item.cmd = (k == 0) ? cmd : 1'($urandom);
         item.a   = operand_limb(kind_a, k);
         item.b   = operand_limb(kind_b, k);
         staged.push_back(item);
      end
   endtask

   // Every limb the same; the command flips after the first transaction and must be ignored.
   task automatic stage_flat_operation(input logic cmd, input logic [LIMB_W-1:0] a,
                                       input logic [LIMB_W-1:0] b);
      limb_pair_type item;
      for (int k = 0; k < OP_ITEMS; k++) begin
         item.cmd = (k == 0) ? cmd : ~cmd;
         item.a   = a;
         item.b   = b;
         staged.push_back(item);
      end
   endtask

   task automatic feed(input int count);
      for (int k = 0; k < count && staged.size() != 0; k++)
         pair_queue.push_back(staged.pop_front());
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pair_queue.size() != 0 || req_push || result_limbs_due.size() != 0);
   endtask

   task automatic write_modulus(input int idx, input logic [LIMB_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 8);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx < MOD_REGS)
         modulus_p[idx] = value;
   endtask

   task automatic load_modulus(input modulus_kind_type kind);
      logic [LIMB_W-1:0] value;
      for (int i = 0; i < MOD_REGS; i++) begin
         case (kind)
            MOD_ONES: value = '1;
            MOD_ZERO: value = '0;
            MOD_ONE: value = (i == 0) ? LIMB_W'(1) : '0;
            MOD_SMALL_TOP: begin
               value = {$urandom, $urandom};
               if (i == MOD_REGS - 1) value = LIMB_W'($urandom_range(1, 65535));
            end
            default: begin
               value = {$urandom, $urandom};
               if (i == MOD_REGS - 1) value[LIMB_W-1] = 1'b1;
            end
         endcase
         write_modulus(i, value);
      end
   endtask

   // Sender side.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            sent_pair.cmd = req_cmd;
            sent_pair.a   = req_limb_a;
            sent_pair.b   = req_limb_b;
            advance_mod_add_sub(sent_pair);
         end
         if (!(req_push && req_full)) begin
            if (pair_queue.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PERCENT)) begin
               next_pair = pair_queue.pop_front();
               req_push   <= 1'b1;
               req_cmd    <= next_pair.cmd;
               req_limb_a <= next_pair.a;
               req_limb_b <= next_pair.b;
            end else begin
               req_push   <= 1'b0;
               req_cmd    <= 1'($urandom);
               req_limb_a <= {$urandom, $urandom};
               req_limb_b <= {$urandom, $urandom};
            end
         end
      end
   end

   // Receiver side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (result_limbs_due.size() == 0) begin
               errors++;
               if (errors <= PRINT_CAP)
                  $display("%0t: unexpected transaction limb %h index %0d last %0b",
                           $time, rsp_result_limb, rsp_limb_index, rsp_last);
            end else begin
               want = result_limbs_due.pop_front();
               if (rsp_result_limb !== want.limb) begin
                  errors++;
                  if (errors <= PRINT_CAP)
                     $display("%0t: result_limb expected %h actual %h",
                              $time, want.limb, rsp_result_limb);
               end
               if (rsp_limb_index !== want.index) begin
                  errors++;
                  if (errors <= PRINT_CAP)
                     $display("%0t: limb_index expected %0d actual %0d",
                              $time, want.index, rsp_limb_index);
               end
               if (rsp_last !== want.last) begin
                  errors++;
                  if (errors <= PRINT_CAP)
                     $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
               end
            end
         end
         rsp_pop <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      modulus_kind_type phase_kind [5];
      phase_kind = '{MOD_ONES, MOD_ZERO, MOD_ONE, MOD_RANDOM, MOD_SMALL_TOP};
      for (int i = 0; i < MOD_REGS; i++)
         modulus_p[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      load_modulus(MOD_RANDOM);
      stage_flat_operation(CMD_ADD, '1, '1);
      stage_flat_operation(CMD_SUB, '0, '1);
      feed(staged.size());
      wait_drained();

      for (int ph = 0; ph < 5; ph++) begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         load_modulus(phase_kind[ph]);
         // Writes past the last modulus register must leave p alone.
         if (ph == 1) begin
            write_modulus(MOD_REGS, {$urandom, $urandom});
            write_modulus(MOD_REGS + 1, '1);
         end
         no_gaps = (ph == 3);
         stage_operation(CMD_ADD);
         stage_operation(CMD_SUB);
         // Stop halfway through the second operation and let everything come out.
         feed(OP_ITEMS + HALF);
         wait_drained();
         feed(staged.size());
         wait_drained();
      end
      no_gaps = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
